// ===== rtl/ckt_pkg.sv =====
// Shared types and constants for the Carmichael number test.
// Holds the operand widths, the sequencer state type and the divider interface structs.
// No dependencies.
`default_nettype none

package ckt_pkg;

  localparam int NUM_WIDTH = 31;
  // Trial divisors never exceed sqrt(2^NUM_WIDTH) + 1.
  localparam int P_W       = NUM_WIDTH / 2 + 2;
  localparam int CNT_W     = $clog2(NUM_WIDTH + 1);

  typedef logic [NUM_WIDTH-1:0] num_t;
  typedef logic [P_W-1:0]       pdiv_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_REST,
    S_DIV_QUO,
    S_DIV_NM1,
    S_TAIL,
    S_DIV_TAIL,
    S_DONE
  } state_t;

  typedef struct packed {
    logic start;
    num_t dividend;
    num_t divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    num_t quotient;
    num_t remainder;
  } div_rsp_t;

endpackage

`default_nettype wire

// ===== rtl/ckt_divider.sv =====
// Bit-serial restoring divider: one quotient bit per cycle.
// Depends on ckt_pkg for widths and the request and response structs.
`default_nettype none

module ckt_divider import ckt_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  num_t             rem;
  num_t             quo;
  num_t             dsr;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic             done;

  logic [NUM_WIDTH:0] shifted;
  logic [NUM_WIDTH:0] diff;
  logic               geq;
  num_t               rem_next;
  num_t               quo_next;

  // Bring down the next dividend bit and try to subtract the divisor.
  always_comb begin
    shifted  = {rem, quo[NUM_WIDTH-1]};
    diff     = shifted - {1'b0, dsr};
    geq      = (shifted >= {1'b0, dsr});
    rem_next = geq ? diff[NUM_WIDTH-1:0] : shifted[NUM_WIDTH-1:0];
    quo_next = {quo[NUM_WIDTH-2:0], geq};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        quo  <= req.dividend;
        rem  <= '0;
        dsr  <= req.divisor;
        cnt  <= CNT_W'(NUM_WIDTH);
        busy <= 1'b1;
      end else if (busy) begin
        rem <= rem_next;
        quo <= quo_next;
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;

endmodule

`default_nettype wire

// ===== rtl/carmichael_number_test.sv =====
// Top level of the Carmichael number test: Korselt sequencer around a serial divider.
// Depends on ckt_pkg and ckt_divider.
`default_nettype none

// Usage
// One transaction on the input channel (in_valid, in_ready, candidate) delivers
// an integer n; exactly one transaction on the output channel (out_valid,
// out_ready, is_carmichael) returns 1 when n is a Carmichael number, else 0.
// The test checks Korselt's criterion by trial division: for each trial
// divisor p with p*p <= rest, a serial divider finds rest / p, and on a hit
// also checks for a square factor and whether p - 1 divides n - 1.
// Every division runs in the one shared divider, so a candidate's run time
// grows with sqrt(n) and with k, the number of prime factors found: it takes
// about sqrt(n) + 2 * k + 1 divisions. Values below 4 skip the divider and
// go straight to the result.
// One candidate is processed at a time; in_ready is high only while the
// sequencer is idle. The result sits in an output register, so a new
// candidate can be taken while an earlier result waits for out_ready. If the
// receiver still stalls when the next result is ready, the sequencer holds in
// its done state until the output register frees up.
// Synchronous reset returns the sequencer to idle and drops out_valid.

module carmichael_number_test import ckt_pkg::*; (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic [NUM_WIDTH-1:0] candidate,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      is_carmichael
);

  state_t     state, state_next;
  num_t       n;
  num_t       nm1;
  num_t       rest, rest_next;
  pdiv_t      p, p_next;
  logic [1:0] factors, factors_next;
  logic       verdict, verdict_next;
  logic       issued;

  div_req_t   req;
  div_rsp_t   rsp;

  ckt_divider u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic div_state;
  logic out_free;
  logic [1:0] factors_inc;

  assign in_ready    = (state == S_IDLE);
  assign out_free    = !out_valid || out_ready;
  assign factors_inc = (factors == 2'd2) ? 2'd2 : factors + 2'd1;

  // Operands follow the state; a new division is launched whenever a division state has none outstanding.
  always_comb begin
    div_state = (state == S_DIV_REST) || (state == S_DIV_QUO) ||
                (state == S_DIV_NM1) || (state == S_DIV_TAIL);
    req.start    = div_state && !issued;
    req.dividend = rest;
    req.divisor  = num_t'(p);
    unique case (state)
      S_DIV_NM1: begin
        req.dividend = nm1;
        req.divisor  = num_t'(p) - num_t'(1);
      end
      S_DIV_TAIL: begin
        req.dividend = nm1;
        req.divisor  = rest - num_t'(1);
      end
      default: begin
        req.dividend = rest;
        req.divisor  = num_t'(p);
      end
    endcase
  end

  always_comb begin
    state_next   = state;
    rest_next    = rest;
    p_next       = p;
    factors_next = factors;
    verdict_next = verdict;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          rest_next    = candidate;
          p_next       = pdiv_t'(2);
          factors_next = 2'd0;
          verdict_next = 1'b0;
          state_next   = (candidate < num_t'(4)) ? S_DONE : S_DIV_REST;
        end
      end
      S_DIV_REST: begin
        if (rsp.done) begin
          if (rsp.quotient < num_t'(p)) begin
            state_next = S_TAIL;
          end else if (rsp.remainder == '0) begin
            rest_next  = rsp.quotient;
            state_next = S_DIV_QUO;
          end else begin
            p_next = p + pdiv_t'(1);
          end
        end
      end
      S_DIV_QUO: begin
        if (rsp.done) begin
          // A second hit on the same divisor means a square factor.
          state_next = (rsp.remainder == '0) ? S_DONE : S_DIV_NM1;
        end
      end
      S_DIV_NM1: begin
        if (rsp.done) begin
          if (rsp.remainder != '0) begin
            state_next = S_DONE;
          end else begin
            factors_next = factors_inc;
            p_next       = p + pdiv_t'(1);
            state_next   = S_DIV_REST;
          end
        end
      end
      S_TAIL: begin
        if (rest > num_t'(1)) begin
          // An untouched rest means n itself is prime.
          state_next = (rest == n) ? S_DONE : S_DIV_TAIL;
        end else begin
          verdict_next = (factors == 2'd2);
          state_next   = S_DONE;
        end
      end
      S_DIV_TAIL: begin
        if (rsp.done) begin
          verdict_next = (rsp.remainder == '0) && (factors_inc == 2'd2);
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (req.start) begin
        issued <= 1'b1;
      end else if (rsp.done) begin
        issued <= 1'b0;
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    rest    <= rest_next;
    p       <= p_next;
    factors <= factors_next;
    verdict <= verdict_next;
    if (state == S_IDLE && in_valid) begin
      n   <= candidate;
      nm1 <= candidate - num_t'(1);
    end
    if (state == S_DONE && out_free) begin
      is_carmichael <= verdict;
    end
  end

endmodule

`default_nettype wire

// ===== tb/carmichael_checker.sv =====
// Checker for the Carmichael number test: watches both channels, predicts each verdict
// from Korselt's criterion and compares it with the block's output.
// Depends on ckt_pkg for NUM_WIDTH.
module carmichael_checker import ckt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic                 in_ready,
  input  logic [NUM_WIDTH-1:0] candidate,
  input  logic                 out_valid,
  input  logic                 out_ready,
  input  logic                 is_carmichael,
  output int                   fail_count,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  bit expected_flags[$];

  // Korselt: composite, squarefree, and p - 1 divides n - 1 for every prime p | n.
  function automatic bit korselt_verdict(logic [NUM_WIDTH-1:0] value);
    longint unsigned n, rest, nm1, p;
    int factors;
    n = value;
    rest = n;
    factors = 0;
    if (n < 4) return 0;
    nm1 = n - 1;
    for (p = 2; p <= rest / p; p++) begin
      if (rest % p == 0) begin
        rest = rest / p;
        if (rest % p == 0) return 0;
        if (nm1 % (p - 1) != 0) return 0;
        factors++;
      end
    end
    if (rest > 1) begin
      if (rest == n) return 0;
      if (nm1 % (rest - 1) != 0) return 0;
      factors++;
    end
    return factors >= 2;
  endfunction

  assign pending = expected_flags.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) expected_flags.push_back(korselt_verdict(candidate));
      if (out_valid && out_ready) begin
        if (expected_flags.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0d", $time, is_carmichael);
          fail_count <= fail_count + 1;
        end else if (expected_flags[0] !== is_carmichael) begin
          $display("%0t: is_carmichael mismatch, expected %0d, actual %0d",
                   $time, expected_flags[0], is_carmichael);
          fail_count <= fail_count + 1;
          void'(expected_flags.pop_front());
        end else begin
          void'(expected_flags.pop_front());
        end
      end
    end
  end
endmodule

// ===== tb/tb_carmichael_number_test.sv =====
// Testbench top for the Carmichael number test: clock, reset, candidate stimulus
// and the verdict. Depends on ckt_pkg, carmichael_number_test and carmichael_checker.
module tb_carmichael_number_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ckt_pkg::*;

  localparam int RANDOM_ITEMS = 81;
  // The final stretch of transactions runs without any idling on either side.
  localparam int QUIET_TAIL = 20;

  logic                 clk;
  logic                 rst;
  logic                 in_valid;
  logic                 in_ready;
  logic [NUM_WIDTH-1:0] candidate;
  logic                 out_valid;
  logic                 out_ready;
  logic                 is_carmichael;
  int                   fail_count;
  int                   pending;
  bit                   quiet;

  carmichael_number_test DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .candidate(candidate),
    .out_valid(out_valid), .out_ready(out_ready), .is_carmichael(is_carmichael)
  );

  carmichael_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .candidate(candidate),
    .out_valid(out_valid), .out_ready(out_ready), .is_carmichael(is_carmichael),
    .fail_count(fail_count), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Known Carmichael numbers small enough that trial division stays quick.
  int unsigned carmichael_list[] = '{561, 1105, 1729, 2465, 2821, 6601, 8911, 10585,
                                     15841, 29341, 41041, 46657, 52633, 62745, 63973};

  // The receiver stalls in random bursts until the quiet tail.
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= (stall_left == 1);
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 11);
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Presents one candidate, holds it until the transaction completes, then
  // either drops valid for a random gap or leaves it high for the next one.
  task automatic send_candidate(logic [NUM_WIDTH-1:0] value);
    int gap;
    in_valid  <= 1'b1;
    candidate <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_valid  <= 1'b0;
      candidate <= NUM_WIDTH'($urandom);
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random candidates are small, since run time grows with sqrt(n), but for multiples of four.
  function automatic logic [NUM_WIDTH-1:0] pick_candidate();
    int unsigned pick;
    int unsigned root;
    pick = $urandom_range(0, 9);
    if (pick < 4) return NUM_WIDTH'(carmichael_list[$urandom_range(0, carmichael_list.size() - 1)]);
    if (pick < 5) return NUM_WIDTH'($urandom_range(0, 15));
    if (pick < 6) begin
      // Square factor times a random cofactor.
      root = $urandom_range(2, 40);
      return NUM_WIDTH'(root * root * $urandom_range(1, 30));
    end
    if (pick < 7) begin
      // Large value with a factor of four: rejected after the first divisor.
      return NUM_WIDTH'({$urandom_range(0, 32'h1FFF_FFFF), 2'b00});
    end
    return NUM_WIDTH'($urandom_range(4, 20000));
  endfunction

  initial begin
    rst       = 1'b1;
    in_valid  = 1'b0;
    candidate = '0;
    quiet     = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: values below four, primes, square factors, other composites, Carmichael numbers,
    // and wide values that are multiples of four and so fail fast.
    send_candidate(0);
    send_candidate(1);
    send_candidate(2);
    send_candidate(3);
    send_candidate(4);
    send_candidate(5);
    send_candidate(9);
    send_candidate(15);
    send_candidate(561);
    send_candidate(1105);
    send_candidate(1729);
    send_candidate(7919);
    send_candidate(8911);
    send_candidate(63973);
    send_candidate(65535);
    send_candidate(NUM_WIDTH'(32'h7FFF_FFFC));
    send_candidate(NUM_WIDTH'(32'h4000_0000));
    send_candidate(NUM_WIDTH'(32'h5555_5554));
    send_candidate(NUM_WIDTH'(32'h2AAA_AAA8));

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS - QUIET_TAIL) quiet = 1'b1;
      send_candidate(pick_candidate());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // Generous fixed limit, well above the slowest correct run.
  initial begin
    #40ms;
    $display("status: fail");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/ckt_pkg.sv
rtl/ckt_divider.sv
rtl/carmichael_number_test.sv
tb/carmichael_checker.sv
tb/tb_carmichael_number_test.sv
